### rtl/htdlp_pkg.sv
// ----------------------------------------------------------------------------
// Hash table package
// Shared widths, operation codes and status codes for the linear-probing
// hash table.
// ----------------------------------------------------------------------------
package htdlp_pkg;

    localparam int KEY_W              = 32;
    localparam int KIND_W             = 2;
    localparam int STATUS_W           = 3;
    localparam int SLOT_W             = 10;
    localparam int COUNT_W            = 32;
    localparam int DIV_BITS           = 4;
    localparam int TABLE_SIZE_DEFAULT = 1021;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_CLEARED   = 3'd5
    } status_t;

endpackage

### rtl/hash_table_division_linear_probe_top.sv
// ----------------------------------------------------------------------------
// Hash table with division hash and linear probing
// Open-addressing table of 32-bit keys supporting insert, search and clear.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   kind, key
//   out      out_valid / out_ready status, slot, collision_count, hit_count
//
// The front end accepts a transaction, reduces key mod TABLE_SIZE at 4 key
// bits per cycle, and pushes the result into a two-entry queue before it
// takes the next one. The probe engine starts from its idle state, probes
// one slot of the slot memory per cycle, and for a clear writes every slot.
// After reset a clearing pass over every slot runs with in_ready low.
// Either side may stall; the queue and the output register decouple them.
// ----------------------------------------------------------------------------
module hash_table_division_linear_probe_top #(
    parameter int TABLE_SIZE = htdlp_pkg::TABLE_SIZE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [htdlp_pkg::KIND_W-1:0]    kind,
    input  logic [htdlp_pkg::KEY_W-1:0]     key,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [htdlp_pkg::STATUS_W-1:0]  status,
    output logic [htdlp_pkg::SLOT_W-1:0]    slot,
    output logic [htdlp_pkg::COUNT_W-1:0]   collision_count,
    output logic [htdlp_pkg::COUNT_W-1:0]   hit_count
);
    import htdlp_pkg::*;

    localparam int RW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int QW = KIND_W + KEY_W + RW;

    logic          push_valid;
    logic          push_ready;
    logic [QW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [QW-1:0] pop_data;
    logic          init_busy;

    htdlp_front #(
        .TABLE_SIZE (TABLE_SIZE),
        .RW         (RW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .key        (key),
        .hold       (init_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    htdlp_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    htdlp_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .RW         (RW)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_data        (pop_data),
        .init_busy       (init_busy),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .slot            (slot),
        .collision_count (collision_count),
        .hit_count       (hit_count)
    );

endmodule

### rtl/htdlp_front.sv
// ----------------------------------------------------------------------------
// Hash table front end
// Accepts operations, drops unused codes and computes the home slot of the
// key as key mod TABLE_SIZE, DIV_BITS key bits per cycle.
// ----------------------------------------------------------------------------
module htdlp_front #(
    parameter int TABLE_SIZE = 1021,
    parameter int RW         = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [htdlp_pkg::KIND_W-1:0]  kind,
    input  logic [htdlp_pkg::KEY_W-1:0]   key,
    input  logic                          hold,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic [htdlp_pkg::KIND_W+htdlp_pkg::KEY_W+RW-1:0] push_data
);
    import htdlp_pkg::*;

    localparam int DIV_STEPS = KEY_W / DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam logic [RW:0]       MOD_EXT   = (RW+1)'(TABLE_SIZE);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t          state_reg, state_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [KEY_W-1:0]      shift_reg, shift_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [RW-1:0]         rem_step;
    logic [RW:0]           ext;

    always_comb
    begin
        rem_step = rem_reg;
        ext      = '0;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            ext = {rem_step, shift_reg[KEY_W-1-j]};
            if (ext >= MOD_EXT)
            begin
                ext = ext - MOD_EXT;
            end
            rem_step = ext[RW-1:0];
        end
    end

    assign in_ready   = (state_reg == F_IDLE) && !hold;
    assign push_valid = (state_reg == F_PUSH);
    assign push_data  = {kind_reg, key_reg, rem_reg};

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        key_next   = key_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    kind_next  = kind;
                    key_next   = key;
                    shift_next = key;
                    rem_next   = '0;
                    step_next  = '0;
                    if (kind inside {KIND_INSERT, KIND_SEARCH, KIND_CLEAR})
                    begin
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                rem_next   = rem_step;
                shift_next = shift_reg << DIV_BITS;
                step_next  = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        key_reg   <= key_next;
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

endmodule

### rtl/htdlp_fifo.sv
// ----------------------------------------------------------------------------
// Hash table operation queue
// Two-entry queue that decouples the front end from the probe engine.
// ----------------------------------------------------------------------------
module htdlp_fifo #(
    parameter int WIDTH = 44
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    import htdlp_pkg::*;

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/htdlp_back.sv
// ----------------------------------------------------------------------------
// Hash table probe engine
// Holds the slot memory and runs insert, search and clear one transaction
// at a time, one probe per cycle, with a registered result.
// ----------------------------------------------------------------------------
module htdlp_back #(
    parameter int TABLE_SIZE = 1021,
    parameter int RW         = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  logic [htdlp_pkg::KIND_W+htdlp_pkg::KEY_W+RW-1:0] pop_data,
    output logic                            init_busy,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [htdlp_pkg::STATUS_W-1:0]  status,
    output logic [htdlp_pkg::SLOT_W-1:0]    slot,
    output logic [htdlp_pkg::COUNT_W-1:0]   collision_count,
    output logic [htdlp_pkg::COUNT_W-1:0]   hit_count
);
    import htdlp_pkg::*;

    localparam logic [RW-1:0] LAST = RW'(TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_CHECK = 3'b010,
        B_CLEAR = 3'b100
    } back_state_t;

    logic [KEY_W:0]        mem [TABLE_SIZE];
    logic [KEY_W:0]        rdata_reg;
    logic [RW-1:0]         rd_addr;
    logic                  mem_we;
    logic [RW-1:0]         mem_wa;
    logic [KEY_W:0]        mem_wd;

    back_state_t           state_reg, state_next;
    logic                  init_reg, init_next;
    logic [RW-1:0]         pos_reg, pos_next;
    logic [RW-1:0]         cnt_reg, cnt_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    kind_t                 kind_reg, kind_next;
    logic [COUNT_W-1:0]    coll_reg, coll_next;
    logic [COUNT_W-1:0]    hits_reg, hits_next;
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic [COUNT_W-1:0]    out_coll_reg, out_coll_next;
    logic [COUNT_W-1:0]    out_hits_reg, out_hits_next;

    logic [KIND_W-1:0]     q_kind;
    logic [KEY_W-1:0]      q_key;
    logic [RW-1:0]         q_home;
    logic [RW-1:0]         pos_inc;
    logic                  entry_valid;
    logic                  entry_match;
    logic                  last_probe;
    logic                  finish;
    status_t               fin_status;
    logic [SLOT_W-1:0]     fin_slot;

    assign {q_kind, q_key, q_home} = pop_data;
    assign pos_inc     = (pos_reg == LAST) ? '0 : pos_reg + 1'b1;
    assign entry_valid = rdata_reg[KEY_W];
    assign entry_match = (rdata_reg[KEY_W-1:0] == key_reg);
    assign last_probe  = (cnt_reg == LAST);

    assign pop_ready       = (state_reg == B_IDLE) && (!out_valid_reg || out_ready);
    assign init_busy       = init_reg;
    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign slot            = out_slot_reg;
    assign collision_count = out_coll_reg;
    assign hit_count       = out_hits_reg;

    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        kind_next  = kind_reg;
        coll_next  = coll_reg;
        hits_next  = hits_reg;
        rd_addr    = q_home;
        mem_we     = 1'b0;
        mem_wa     = pos_reg;
        mem_wd     = '0;
        finish     = 1'b0;
        fin_status = ST_CLEARED;
        fin_slot   = '0;
        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid && pop_ready)
                begin
                    key_next  = q_key;
                    kind_next = kind_t'(q_kind);
                    cnt_next  = '0;
                    if (kind_t'(q_kind) == KIND_CLEAR)
                    begin
                        pos_next   = '0;
                        state_next = B_CLEAR;
                    end
                    else
                    begin
                        pos_next   = q_home;
                        state_next = B_CHECK;
                    end
                end
            end
            B_CHECK:
            begin
                rd_addr = pos_inc;
                if (kind_reg == KIND_INSERT)
                begin
                    if (!entry_valid)
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = {1'b1, key_reg};
                        finish     = 1'b1;
                        fin_status = ST_INSERTED;
                        fin_slot   = SLOT_W'(pos_reg);
                    end
                    else if (entry_match)
                    begin
                        finish     = 1'b1;
                        fin_status = ST_DUPLICATE;
                    end
                    else
                    begin
                        coll_next = coll_reg + 1'b1;
                        if (last_probe)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_FULL;
                        end
                    end
                end
                else
                begin
                    if (!entry_valid)
                    begin
                        finish     = 1'b1;
                        fin_status = ST_NOT_FOUND;
                    end
                    else if (entry_match)
                    begin
                        hits_next  = hits_reg + 1'b1;
                        finish     = 1'b1;
                        fin_status = ST_FOUND;
                        fin_slot   = SLOT_W'(pos_reg);
                    end
                    else if (last_probe)
                    begin
                        finish     = 1'b1;
                        fin_status = ST_NOT_FOUND;
                    end
                end
                if (finish)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    pos_next = pos_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            B_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wa   = pos_reg;
                pos_next = pos_inc;
                if (pos_reg == LAST)
                begin
                    state_next = B_IDLE;
                    init_next  = 1'b0;
                    finish     = !init_reg;
                    fin_status = ST_CLEARED;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_coll_next   = out_coll_reg;
        out_hits_next   = out_hits_reg;
        if (finish)
        begin
            out_valid_next  = 1'b1;
            out_status_next = fin_status;
            out_slot_next   = fin_slot;
            out_coll_next   = coll_next;
            out_hits_next   = hits_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            init_reg      <= 1'b1;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            kind_reg      <= KIND_INSERT;
            coll_reg      <= '0;
            hits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            kind_reg      <= kind_next;
            coll_reg      <= coll_next;
            hits_reg      <= hits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_coll_reg   <= out_coll_next;
        out_hits_reg   <= out_hits_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[rd_addr];
    end

endmodule
